@@ src/assert_macros.svh @@
// Assertion macros shared by the scroll and address register unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SAR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define SAR_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ src/sar_pkg.sv @@
// Types and constants of the scroll and address register unit.
`timescale 1ns / 1ps

package sar_pkg;

	// Operation codes of one input item.
	typedef enum logic [1:0] {
		OP_REG_WRITE = 2'd0,
		OP_COARSE_X  = 2'd1,
		OP_FINE_Y    = 2'd2
	} op_t;

	// Register indexes for a register write.
	localparam logic [2:0] REG_CTRL   = 3'd0;
	localparam logic [2:0] REG_SCROLL = 3'd5;
	localparam logic [2:0] REG_ADDR   = 3'd6;
	localparam logic [2:0] REG_DATA   = 3'd7;

	// Coarse and fine values at which the address steps wrap.
	localparam logic [4:0] COARSE_Y_LAST_ROW = 5'd29;
	localparam logic [4:0] COARSE_MAX        = 5'd31;
	localparam logic [2:0] FINE_MAX          = 3'd7;

	// Address increments of the data register.
	localparam logic [14:0] STEP_ONE  = 15'd1;
	localparam logic [14:0] STEP_ROW  = 15'd32;

	// Architectural state of the unit.
	typedef struct packed {
		logic [14:0] tmp;
		logic [14:0] cur;
		logic [2:0]  fine_x;
		logic        toggle;
		logic        step_by_32;
	} state_t;

	// Video memory write that one item produces.
	typedef struct packed {
		logic        wr;
		logic [13:0] addr;
		logic [7:0]  data;
	} mem_wr_t;

endpackage

@@ src/sar_step.sv @@
// Next-state and memory write logic for one item of the scroll and address register unit.
`timescale 1ns / 1ps

module sar_step (
	input  sar_pkg::state_t  state,
	input  logic [1:0]       op,
	input  logic [2:0]       reg_sel,
	input  logic [7:0]       data,
	output sar_pkg::state_t  state_next,
	output sar_pkg::mem_wr_t mem_wr
);

	logic [4:0] coarse_y;

	assign coarse_y = state.cur[9:5];

	// Decode the item and build the next state
	always_comb begin
		state_next = state;
		mem_wr     = '0;
		unique case (op)
			sar_pkg::OP_REG_WRITE: begin
				unique case (reg_sel)
					sar_pkg::REG_CTRL: begin
						state_next.tmp[11:10]  = data[1:0];
						state_next.step_by_32  = data[2];
					end
					sar_pkg::REG_SCROLL: begin
						if (!state.toggle) begin
							state_next.tmp[4:0]  = data[7:3];
							state_next.fine_x    = data[2:0];
						end else begin
							state_next.tmp[14:12] = data[2:0];
							state_next.tmp[9:5]   = data[7:3];
						end
						state_next.toggle = ~state.toggle;
					end
					sar_pkg::REG_ADDR: begin
						if (!state.toggle) begin
							state_next.tmp = {1'b0, data[5:0], state.tmp[7:0]};
						end else begin
							state_next.tmp = {state.tmp[14:8], data};
							state_next.cur = {state.tmp[14:8], data};
						end
						state_next.toggle = ~state.toggle;
					end
					sar_pkg::REG_DATA: begin
						mem_wr.wr   = 1'b1;
						mem_wr.addr = state.cur[13:0];
						mem_wr.data = data;
						state_next.cur = state.cur +
							(state.step_by_32 ? sar_pkg::STEP_ROW : sar_pkg::STEP_ONE);
					end
					default: begin
					end
				endcase
			end
			sar_pkg::OP_COARSE_X: begin
				// wrap coarse X and flip the horizontal nametable
				if (state.cur[4:0] == sar_pkg::COARSE_MAX) begin
					state_next.cur[4:0] = '0;
					state_next.cur[10]  = ~state.cur[10];
				end else begin
					state_next.cur[4:0] = state.cur[4:0] + 5'd1;
				end
			end
			sar_pkg::OP_FINE_Y: begin
				if (state.cur[14:12] != sar_pkg::FINE_MAX) begin
					state_next.cur[14:12] = state.cur[14:12] + 3'd1;
				end else begin
					// carry into coarse Y
					state_next.cur[14:12] = '0;
					if (coarse_y == sar_pkg::COARSE_Y_LAST_ROW) begin
						state_next.cur[9:5] = '0;
						state_next.cur[11]  = ~state.cur[11];
					end else if (coarse_y == sar_pkg::COARSE_MAX) begin
						state_next.cur[9:5] = '0;
					end else begin
						state_next.cur[9:5] = coarse_y + 5'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ src/scroll_address_registers_top.sv @@
// Top level of the scroll and address register unit.
// Each item passes through two registers: the input register, then the result register.
// Throughput: one item per cycle while the result side does not stall; the state update sits between the two registers.
// A stalled result holds the result register, and the input register then fills and stalls.
// Reset (arst_n low, asynchronous) clears all address, scroll, toggle and step state
// and empties both registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scroll_address_registers_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [2:0]  reg_sel,
	input  logic [7:0]  data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        mem_write,
	output logic [13:0] mem_addr,
	output logic [7:0]  mem_data,
	output logic [14:0] cur_addr,
	output logic [14:0] tmp_addr,
	output logic [2:0]  fine_x_out,
	output logic        toggle_out
);

	logic             valid_s1;
	logic [1:0]       op_s1;
	logic [2:0]       reg_sel_s1;
	logic [7:0]       data_s1;
	logic             out_free;
	logic             fire_s1;
	logic             in_xfer;
	sar_pkg::state_t  state_q;
	sar_pkg::state_t  state_next;
	sar_pkg::mem_wr_t mem_wr;
	logic             out_valid_q;
	sar_pkg::mem_wr_t out_mem_q;
	sar_pkg::state_t  out_state_q;

	// Handshake: result register frees on transfer, input register advances into it
	assign out_free = !out_valid_q || !out_stall;
	assign fire_s1  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_xfer  = in_valid && !in_stall;

	// Input register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1      <= op;
			reg_sel_s1 <= reg_sel;
			data_s1    <= data;
		end
	end

	sar_step u_step (
		.state      (state_q),
		.op         (op_s1),
		.reg_sel    (reg_sel_s1),
		.data       (data_s1),
		.state_next (state_next),
		.mem_wr     (mem_wr)
	);

	// Advance the architectural state once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire_s1) begin
			state_q <= state_next;
		end
	end

	// Result register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire_s1;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_mem_q   <= mem_wr;
			out_state_q <= state_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign mem_write  = out_mem_q.wr;
	assign mem_addr   = out_mem_q.addr;
	assign mem_data   = out_mem_q.data;
	assign cur_addr   = out_state_q.cur;
	assign tmp_addr   = out_state_q.tmp;
	assign fine_x_out = out_state_q.fine_x;
	assign toggle_out = out_state_q.toggle;

	// State moves only when an item completes
	`SAR_ASSERT(a_state_hold, clk, arst_n, !fire_s1 |=> $stable(state_q), "state changed without an item")
	// A completed item always reaches the result register
	`SAR_ASSERT(a_fire_loads, clk, arst_n, fire_s1 |=> out_valid_q, "item lost before the result register")
	// A pending result reflects the live state
	`SAR_ASSERT(a_result_state, clk, arst_n, out_valid_q |-> (out_state_q == state_q), "result disagrees with state")
	// Never accept while the input register is held
	`SAR_NEVER(a_no_overrun, clk, arst_n, in_xfer && valid_s1 && !fire_s1, "input register overrun")

endmodule

@@ tb/sv/scroll_address_registers_checker.sv @@
// Checker that watches both channels of the scroll and address register unit and scores results.
`timescale 1ns / 1ps

module scroll_address_registers_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  op,
	input  logic [2:0]  reg_sel,
	input  logic [7:0]  data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        mem_write,
	input  logic [13:0] mem_addr,
	input  logic [7:0]  mem_data,
	input  logic [14:0] cur_addr,
	input  logic [14:0] tmp_addr,
	input  logic [2:0]  fine_x_out,
	input  logic        toggle_out,
	output int          mismatches,
	output int          outstanding
);

	// Everything the unit reports after one transfer
	typedef struct packed {
		sar_pkg::mem_wr_t mem;
		logic [14:0]      cur;
		logic [14:0]      tmp;
		logic [2:0]       fine_x;
		logic             toggle;
	} scroll_view_t;

	logic [14:0] tmp_q   = '0;
	logic [14:0] cur_q   = '0;
	logic [2:0]  fine_x_q = '0;
	logic        toggle_q = 1'b0;
	logic        row_step_q = 1'b0;

	scroll_view_t pending_views[$];

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	// Advance the scroll state by one input transfer and return what the unit should show
	function automatic scroll_view_t advance_scroll(input logic [1:0] kind, input logic [2:0] sel,
			input logic [7:0] d);
		scroll_view_t v;
		v = '0;
		case (kind)
			sar_pkg::OP_REG_WRITE: begin
				case (sel)
					sar_pkg::REG_CTRL: begin
						tmp_q[11:10] = d[1:0];
						row_step_q   = d[2];
					end
					sar_pkg::REG_SCROLL: begin
						if (!toggle_q) begin
							tmp_q[4:0] = d[7:3];
							fine_x_q   = d[2:0];
						end else begin
							tmp_q[14:12] = d[2:0];
							tmp_q[9:5]   = d[7:3];
						end
						toggle_q = !toggle_q;
					end
					sar_pkg::REG_ADDR: begin
						if (!toggle_q) begin
							tmp_q[13:8] = d[5:0];
							tmp_q[14]   = 1'b0;
						end else begin
							tmp_q[7:0] = d;
							cur_q      = tmp_q;
						end
						toggle_q = !toggle_q;
					end
					sar_pkg::REG_DATA: begin
						v.mem.wr   = 1'b1;
						v.mem.addr = cur_q[13:0];
						v.mem.data = d;
						cur_q      = cur_q +
							(row_step_q ? sar_pkg::STEP_ROW : sar_pkg::STEP_ONE);
					end
					default: ;
				endcase
			end
			sar_pkg::OP_COARSE_X: begin
				// wrap coarse X into the neighbouring horizontal nametable
				if (cur_q[4:0] == sar_pkg::COARSE_MAX) begin
					cur_q[4:0] = '0;
					cur_q[10]  = !cur_q[10];
				end else begin
					cur_q[4:0] = cur_q[4:0] + 5'd1;
				end
			end
			sar_pkg::OP_FINE_Y: begin
				// carry fine Y into coarse Y; row 29 flips the vertical nametable
				if (cur_q[14:12] != sar_pkg::FINE_MAX) begin
					cur_q[14:12] = cur_q[14:12] + 3'd1;
				end else begin
					cur_q[14:12] = '0;
					if (cur_q[9:5] == sar_pkg::COARSE_Y_LAST_ROW) begin
						cur_q[9:5] = '0;
						cur_q[11]  = !cur_q[11];
					end else if (cur_q[9:5] == sar_pkg::COARSE_MAX) begin
						cur_q[9:5] = '0;
					end else begin
						cur_q[9:5] = cur_q[9:5] + 5'd1;
					end
				end
			end
			default: ;
		endcase
		v.cur    = cur_q;
		v.tmp    = tmp_q;
		v.fine_x = fine_x_q;
		v.toggle = toggle_q;
		return v;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	// Score result transfers against the oldest prediction, then log new input transfers
	always @(posedge clk) begin
		scroll_view_t want;
		if (!arst_n) begin
			tmp_q      = '0;
			cur_q      = '0;
			fine_x_q   = '0;
			toggle_q   = 1'b0;
			row_step_q = 1'b0;
			pending_views.delete();
		end else begin
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (pending_views.size() == 0) begin
					report_mismatch("result with nothing pending", 1, 0);
				end else begin
					want = pending_views.pop_front();
					if (mem_write !== want.mem.wr)
						report_mismatch("mem_write", mem_write, want.mem.wr);
					if (mem_addr !== want.mem.addr)
						report_mismatch("mem_addr", mem_addr, want.mem.addr);
					if (mem_data !== want.mem.data)
						report_mismatch("mem_data", mem_data, want.mem.data);
					if (cur_addr !== want.cur)
						report_mismatch("cur_addr", cur_addr, want.cur);
					if (tmp_addr !== want.tmp)
						report_mismatch("tmp_addr", tmp_addr, want.tmp);
					if (fine_x_out !== want.fine_x)
						report_mismatch("fine_x_out", fine_x_out, want.fine_x);
					if (toggle_out !== want.toggle)
						report_mismatch("toggle_out", toggle_out, want.toggle);
				end
			end
			if (in_valid === 1'b1 && in_stall === 1'b0)
				pending_views.push_back(advance_scroll(op, reg_sel, data));
		end
		outstanding <= pending_views.size();
	end

endmodule

@@ tb/sv/scroll_address_registers_top_test.sv @@
// Stimulus, reset, flow control and verdict for the scroll and address register unit.
`timescale 1ns / 1ps

module scroll_address_registers_top_test;

	localparam logic [1:0] OP_UNUSED    = 2'd3;
	localparam logic [2:0] REG_SPARE_LO = 3'd1;
	localparam logic [2:0] REG_SPARE_HI = 3'd4;
	localparam int QUIET_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        out_stall = 1'b0;
	logic [1:0]  op        = '0;
	logic [2:0]  reg_sel   = '0;
	logic [7:0]  data      = '0;
	logic        in_stall;
	logic        out_valid;
	logic        mem_write;
	logic [13:0] mem_addr;
	logic [7:0]  mem_data;
	logic [14:0] cur_addr;
	logic [14:0] tmp_addr;
	logic [2:0]  fine_x_out;
	logic        toggle_out;

	int mismatches;
	int outstanding;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;
	int sent           = 0;
	bit hold_request   = 1'b0;
	bit second_write   = 1'b0;

	scroll_address_registers_top dut (.*);

	scroll_address_registers_checker checker_i (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Offer one item after a random gap and hold it until the transfer
	task automatic send_item(input logic [1:0] kind, input logic [2:0] sel, input logic [7:0] d);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op       <= kind;
		reg_sel  <= sel;
		data     <= d;
		do @(posedge clk); while (in_stall);
		if (kind == sar_pkg::OP_REG_WRITE &&
				(sel == sar_pkg::REG_SCROLL || sel == sar_pkg::REG_ADDR))
			second_write = !second_write;
		sent++;
	endtask

	// Bring the write toggle back to first write with a throwaway scroll write
	task automatic realign_toggle();
		if (second_write)
			send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_SCROLL, 8'($urandom));
	endtask

	// One well-formed register sequence with random content, or a burst of noise
	task automatic random_sequence();
		int pick;
		int len;
		int fine_pct;
		pick     = $urandom_range(99);
		len      = $urandom_range(1, 12);
		fine_pct = $urandom_range(1) ? 85 : 30;
		if (pick < 30) begin
			// set the address, then walk it as rendering would
			realign_toggle();
			send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_ADDR, 8'($urandom));
			send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_ADDR, 8'($urandom));
			repeat ($urandom_range(1, 40))
				send_item(($urandom_range(99) < fine_pct) ? sar_pkg::OP_FINE_Y :
					sar_pkg::OP_COARSE_X, 3'($urandom), 8'($urandom));
		end else if (pick < 45) begin
			realign_toggle();
			send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_CTRL, 8'($urandom));
			send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_SCROLL, 8'($urandom));
			send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_SCROLL, 8'($urandom));
		end else if (pick < 65) begin
			// memory upload at the current address
			if ($urandom_range(1))
				send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_CTRL, 8'($urandom));
			repeat (len)
				send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_DATA, 8'($urandom));
		end else if (pick < 85) begin
			realign_toggle();
			send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_ADDR, 8'($urandom));
			send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_ADDR, 8'($urandom));
			repeat (len)
				send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_DATA, 8'($urandom));
		end else begin
			repeat ($urandom_range(1, 4))
				send_item(2'($urandom_range(3)), 3'($urandom), 8'($urandom));
		end
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int items);
		int stop_at;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		stop_at        = sent + items;
		while (sent < stop_at)
			random_sequence();
	endtask

	// Drive the result stall; a requested hold-off wins over random stalls
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Abort when neither channel has moved for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("scroll_address_registers_top_test NOT OK");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// register loads at both extremes of the data byte
		send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_CTRL, 8'hFF);
		send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_CTRL, 8'h00);
		send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_SCROLL, 8'hFF);
		send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_SCROLL, 8'hFF);
		send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_SCROLL, 8'h00);
		send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_SCROLL, 8'h00);
		send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_ADDR, 8'hFF);
		send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_ADDR, 8'hFF);
		// memory writes stepping by one, then by a row
		send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_DATA, 8'hAA);
		send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_CTRL, 8'h04);
		send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_DATA, 8'h55);
		// ignored register indexes and the unused operation
		send_item(sar_pkg::OP_REG_WRITE, REG_SPARE_LO, 8'hFF);
		send_item(sar_pkg::OP_REG_WRITE, REG_SPARE_HI, 8'h00);
		send_item(OP_UNUSED, sar_pkg::REG_DATA, 8'hFF);
		// coarse X at 31 wraps and flips the horizontal nametable
		send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_ADDR, 8'h00);
		send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_ADDR, 8'h1F);
		send_item(sar_pkg::OP_COARSE_X, sar_pkg::REG_CTRL, 8'h00);
		// coarse Y 29 with fine Y 3: four fine steps, then the row wrap
		send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_ADDR, 8'h33);
		send_item(sar_pkg::OP_REG_WRITE, sar_pkg::REG_ADDR, 8'hA0);
		repeat (5)
			send_item(sar_pkg::OP_FINE_Y, sar_pkg::REG_CTRL, 8'h00);

		// keep offering items while the result side holds off
		hold_request = 1'b1;
		run_phase(0, 0, 450);
		run_phase(70, 0, 350);
		run_phase(0, 70, 350);
		run_phase(26, 26, 350);
		run_phase(0, 0, 350);

		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("scroll_address_registers_top_test OK");
		else
			$display("scroll_address_registers_top_test NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+src
src/sar_pkg.sv
src/sar_step.sv
src/scroll_address_registers_top.sv
tb/sv/scroll_address_registers_checker.sv
tb/sv/scroll_address_registers_top_test.sv
